// ===== sv/ttm_pkg.sv =====
`timescale 1ns / 1ps

package ttm_pkg;

    localparam int SampleWidth = 12;

    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_NONREC   = 3'd1;
    localparam logic [2:0] ACT_CRITICAL = 3'd2;
    localparam logic [2:0] ACT_ASSERT   = 3'd3;
    localparam logic [2:0] ACT_DEASSERT = 3'd4;

    localparam logic [1:0] CFG_NONCRIT  = 2'd0;
    localparam logic [1:0] CFG_CRIT     = 2'd1;
    localparam logic [1:0] CFG_NONREC   = 2'd2;
    localparam logic [1:0] CFG_FLOOR    = 2'd3;

    localparam logic [7:0]        NONCRIT_RESET = 8'd255;
    localparam logic [7:0]        CRIT_RESET    = 8'd255;
    localparam logic [7:0]        NONREC_RESET  = 8'd255;
    localparam logic signed [7:0] FLOOR_RESET   = 8'sd30;

    typedef struct packed {
        logic       powered;
        logic [7:0] raw_low;
        logic [7:0] raw_high;
        logic       end_of_scan;
    } item_t;

    typedef struct packed {
        logic [7:0]        noncritical_limit;
        logic [7:0]        critical_limit;
        logic [7:0]        nonrecoverable_limit;
        logic signed [7:0] scan_floor;
    } limits_t;

    typedef struct packed {
        logic signed [SampleWidth-1:0] running_max;
        logic                          first_scan_pending;
        logic                          warning_asserted;
    } mon_state_t;

    typedef struct packed {
        logic [7:0] reading;
        logic       available;
        logic [2:0] action;
    } result_t;

endpackage

// ===== sv/ttm_eval.sv =====
`timescale 1ns / 1ps

module ttm_eval (
    input  ttm_pkg::item_t      item,
    input  ttm_pkg::limits_t    limits,
    input  ttm_pkg::mon_state_t state_cur,
    output logic                has_result,
    output ttm_pkg::result_t    result,
    output ttm_pkg::mon_state_t state_next
);

    logic signed [ttm_pkg::SampleWidth-1:0] sample;
    logic signed [ttm_pkg::SampleWidth-1:0] max_new;
    logic signed [ttm_pkg::SampleWidth-1:0] floor_start;
    logic [7:0]                             reading;

    assign sample      = {item.raw_high, item.raw_low[7:4]};
    assign max_new     = (sample > state_cur.running_max) ? sample : state_cur.running_max;
    assign floor_start = {limits.scan_floor, 4'b0000};
    assign reading     = max_new[ttm_pkg::SampleWidth-1] ? 8'd0 : max_new[11:4];

    always_comb begin
        state_next = state_cur;
        result     = '0;
        has_result = 1'b0;
        if (!item.powered) begin
            state_next.running_max = floor_start;
            has_result             = 1'b1;
        end else if (!item.end_of_scan) begin
            state_next.running_max = max_new;
        end else begin
            has_result             = 1'b1;
            state_next.running_max = floor_start;
            result.reading         = reading;
            result.available       = 1'b1;
            result.action          = ttm_pkg::ACT_NONE;
            if (state_cur.first_scan_pending) begin
                state_next.first_scan_pending = 1'b0;
            end else if (reading >= limits.nonrecoverable_limit) begin
                result.action = ttm_pkg::ACT_NONREC;
            end else if (reading >= limits.critical_limit) begin
                result.action = ttm_pkg::ACT_CRITICAL;
            end else if (!state_cur.warning_asserted
                         && reading >= limits.noncritical_limit) begin
                result.action               = ttm_pkg::ACT_ASSERT;
                state_next.warning_asserted = 1'b1;
            end else if (state_cur.warning_asserted
                         && reading < limits.noncritical_limit) begin
                result.action               = ttm_pkg::ACT_DEASSERT;
                state_next.warning_asserted = 1'b0;
            end
        end
    end

endmodule

// ===== sv/temperature_threshold_monitor_top.sv =====
`timescale 1ns / 1ps

// Temperature threshold monitor.
// Input stream: one channel sample per transaction. s_tdata carries the two
// raw sensor bytes, s_tuser says the payload is powered, s_tlast ends a scan.
// Output stream: one result per scan end or per unpowered sample. m_tdata
// carries the whole-degree maximum and the threshold action, m_tuser flags
// the reading as available.
// Configuration: write cfg_wdata to register cfg_addr while cfg_we is high
// (0 non-critical, 1 critical, 2 non-recoverable limit, 3 scan floor).
// Path: an accepted sample is held in the input register, and its result is
// registered in the output register, which drives m_tvalid. Throughput: one
// sample per cycle while the input does not stall, set by the single
// compare-and-max stage between the two registers.
// Reset: limits return to 255, the floor to 30 degrees, the running maximum
// to the floor, and the first scan after reset reports no action.
// Stall: while m_tready is low the pending result holds; samples that give
// no result keep flowing, and input stalls only when a new result would
// need the occupied output register.
module temperature_threshold_monitor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // raw_low, raw_high
    input  logic        s_tuser,   // powered
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // reading, action, zero fill
    output logic        m_tuser,   // available
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    logic                in_valid_reg;
    ttm_pkg::item_t      in_item_reg;
    ttm_pkg::limits_t    limits_reg;
    ttm_pkg::mon_state_t state_reg;
    ttm_pkg::mon_state_t state_next;
    logic                m_valid_reg;
    ttm_pkg::result_t    result_reg;
    ttm_pkg::result_t    result_next;
    logic                has_result;
    logic                out_free;
    logic                advance;

    ttm_eval u_eval (
        .item       (in_item_reg),
        .limits     (limits_reg),
        .state_cur  (state_reg),
        .has_result (has_result),
        .result     (result_next),
        .state_next (state_next)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!has_result || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_item_reg <= '{powered:     s_tuser,
                             raw_low:     s_tdata[7:0],
                             raw_high:    s_tdata[15:8],
                             end_of_scan: s_tlast};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.running_max        <= {ttm_pkg::FLOOR_RESET, 4'b0000};
            state_reg.first_scan_pending <= 1'b1;
            state_reg.warning_asserted   <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.noncritical_limit    <= ttm_pkg::NONCRIT_RESET;
            limits_reg.critical_limit       <= ttm_pkg::CRIT_RESET;
            limits_reg.nonrecoverable_limit <= ttm_pkg::NONREC_RESET;
            limits_reg.scan_floor           <= ttm_pkg::FLOOR_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ttm_pkg::CFG_NONCRIT: limits_reg.noncritical_limit    <= cfg_wdata;
                ttm_pkg::CFG_CRIT:    limits_reg.critical_limit       <= cfg_wdata;
                ttm_pkg::CFG_NONREC:  limits_reg.nonrecoverable_limit <= cfg_wdata;
                ttm_pkg::CFG_FLOOR:   limits_reg.scan_floor           <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= advance && has_result;
        end
        if (out_free && advance && has_result) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, result_reg.action, result_reg.reading};
    assign m_tuser  = result_reg.available;

    a_unavail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !result_reg.available) |->
            (result_reg.reading == 8'd0 && result_reg.action == ttm_pkg::ACT_NONE))
        else $error("unavailable result carries nonzero fields");

    a_first_scan_stays_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.first_scan_pending |=> !state_reg.first_scan_pending)
        else $error("first scan flag set again without reset");

    a_warn_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !state_reg.warning_asserted && state_next.warning_asserted) |->
            (result_next.action == ttm_pkg::ACT_ASSERT))
        else $error("warning flag set without assert action");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && !in_valid_reg) |-> s_tready)
        else $error("input stalled with empty pipeline");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 150;
    localparam int RAND_PHASES  = 9;
    localparam int DRAIN_CYCLES = 4;
    localparam int PRINT_CAP    = 40;

    class threshold_scoreboard;
        logic [7:0]        nc_lim;
        logic [7:0]        cr_lim;
        logic [7:0]        nr_lim;
        logic signed [7:0] floor_deg;
        logic signed [11:0] run_max;
        bit                first_pending;
        bit                warn_on;
        ttm_pkg::result_t  expected_q[$];
        int                errors;
        int                samples_in;
        int                results_seen;
        int                unavail_seen;
        int                act_seen[5];

        function new();
            nc_lim        = ttm_pkg::NONCRIT_RESET;
            cr_lim        = ttm_pkg::CRIT_RESET;
            nr_lim        = ttm_pkg::NONREC_RESET;
            floor_deg     = ttm_pkg::FLOOR_RESET;
            run_max       = floor_q4();
            first_pending = 1'b1;
            warn_on       = 1'b0;
        endfunction

        function logic signed [11:0] floor_q4();
            return {floor_deg, 4'b0000};
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] value);
            case (idx)
                ttm_pkg::CFG_NONCRIT: nc_lim    = value;
                ttm_pkg::CFG_CRIT:    cr_lim    = value;
                ttm_pkg::CFG_NONREC:  nr_lim    = value;
                ttm_pkg::CFG_FLOOR:   floor_deg = value;
                default: ;
            endcase
        endfunction

        // Work out the result, if any, of one accepted sample.
        function void note_sample(ttm_pkg::item_t it);
            logic signed [11:0] temp_q4;
            ttm_pkg::result_t   r;
            samples_in++;
            r.reading   = 8'd0;
            r.available = 1'b0;
            r.action    = ttm_pkg::ACT_NONE;
            if (!it.powered) begin
                run_max = floor_q4();
                expected_q.push_back(r);
                return;
            end
            temp_q4 = $signed({it.raw_high, it.raw_low[7:4]});
            if (temp_q4 > run_max)
                run_max = temp_q4;
            if (!it.end_of_scan)
                return;
            r.reading   = (run_max < 0) ? 8'd0 : run_max[11:4];
            r.available = 1'b1;
            run_max     = floor_q4();
            if (first_pending) begin
                first_pending = 1'b0;
            end else if (r.reading >= nr_lim) begin
                r.action = ttm_pkg::ACT_NONREC;
            end else if (r.reading >= cr_lim) begin
                r.action = ttm_pkg::ACT_CRITICAL;
            end else if (!warn_on && r.reading >= nc_lim) begin
                r.action = ttm_pkg::ACT_ASSERT;
                warn_on  = 1'b1;
            end else if (warn_on && r.reading < nc_lim) begin
                r.action = ttm_pkg::ACT_DEASSERT;
                warn_on  = 1'b0;
            end
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("tb_top: mismatch on result %0d: %s", results_seen, msg);
        endtask

        task check_result(ttm_pkg::result_t got);
            ttm_pkg::result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected transaction reading %0d available %0d action %0d",
                                 got.reading, got.available, got.action));
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            if (!want.available)
                unavail_seen++;
            else if (want.action <= ttm_pkg::ACT_DEASSERT)
                act_seen[want.action]++;
            if (got.reading !== want.reading)
                report($sformatf("reading %0d, expected %0d", got.reading, want.reading));
            if (got.available !== want.available)
                report($sformatf("available %0d, expected %0d", got.available, want.available));
            if (got.action !== want.action)
                report($sformatf("action %0d, expected %0d", got.action, want.action));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [7:0]  cfg_wdata;

    threshold_scoreboard sb = new();
    int idle_pct = 30;
    bit hold_req = 1'b0;
    int hold_cnt = 0;
    int scan_left = 0;
    int cycle_count = 0;
    int settings_applied = 0;

    temperature_threshold_monitor_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    function automatic ttm_pkg::item_t mk_sample(bit pwr, int q4, bit last);
        ttm_pkg::item_t it;
        logic [11:0]    v;
        v              = q4[11:0];
        it.powered     = pwr;
        it.raw_high    = v[11:4];
        it.raw_low     = {v[3:0], 4'($urandom)};
        it.end_of_scan = last;
        return it;
    endfunction

    // Half fully random, half clustered around a limit or the floor.
    function automatic int rand_temp_q4();
        int deg;
        if ($urandom_range(1) == 0)
            return $urandom_range(4095);
        case ($urandom_range(3))
            0:       deg = int'(sb.nc_lim);
            1:       deg = int'(sb.cr_lim);
            2:       deg = int'(sb.nr_lim);
            default: deg = int'(sb.floor_deg);
        endcase
        deg = deg + int'($urandom_range(4)) - 2;
        if (deg > 127)
            deg = 127;
        if (deg < -128)
            deg = -128;
        return deg * 16 + int'($urandom_range(15));
    endfunction

    function automatic ttm_pkg::item_t next_random_item(int max_len);
        if ($urandom_range(99) < 8) begin
            scan_left = 0;
            return mk_sample(1'b0, $urandom_range(4095), 1'($urandom_range(1)));
        end
        if (scan_left == 0)
            scan_left = $urandom_range(max_len, 1);
        scan_left--;
        return mk_sample(1'b1, rand_temp_q4(), scan_left == 0);
    endfunction

    task automatic send_item(ttm_pkg::item_t it);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.raw_high, it.raw_low};
        s_tuser  <= it.powered;
        s_tlast  <= it.end_of_scan;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_sample(it);
    endtask

    // Hold the input until every pending result is out, then let the pipe settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_limits(logic [7:0] nc, logic [7:0] cr, logic [7:0] nr,
                                logic signed [7:0] fl);
        write_reg(ttm_pkg::CFG_NONCRIT, nc);
        write_reg(ttm_pkg::CFG_CRIT, cr);
        write_reg(ttm_pkg::CFG_NONREC, nr);
        write_reg(ttm_pkg::CFG_FLOOR, fl);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    task automatic apply_random_limits();
        int nc;
        int cr;
        int nr;
        int fl;
        nc = $urandom_range(100);
        cr = nc + $urandom_range(30);
        nr = cr + $urandom_range(30);
        if ($urandom_range(3) == 0)
            nr = 255;
        if (nr > 255)
            nr = 255;
        if ($urandom_range(1) == 0)
            fl = int'($urandom_range(168)) - 128;
        else
            fl = int'($urandom_range(255)) - 128;
        apply_limits(nc[7:0], cr[7:0], nr[7:0], fl[7:0]);
    endtask

    // Result side: check transactions, random back-pressure and one long hold-off.
    initial begin
        ttm_pkg::result_t got;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.reading   = m_tdata[7:0];
                got.action    = m_tdata[10:8];
                got.available = m_tuser;
                sb.check_result(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= ttm_pkg::CFG_NONCRIT;
        cfg_wdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limits: first scan reports no action, then the reset floor applies
        send_item(mk_sample(1'b1, 2047, 1'b0));
        send_item(mk_sample(1'b1, -2048, 1'b1));
        send_item(mk_sample(1'b1, -2048, 1'b1));
        drain();

        apply_limits(8'd20, 8'd100, 8'd120, -8'sd128);
        send_item(mk_sample(1'b0, 0, 1'b0));
        send_item(mk_sample(1'b1, -2048, 1'b1));
        send_item(mk_sample(1'b1, 2047, 1'b1));
        send_item(mk_sample(1'b1, 110 * 16, 1'b1));
        send_item(mk_sample(1'b1, 50 * 16, 1'b1));
        send_item(mk_sample(1'b1, 60 * 16, 1'b1));
        send_item(mk_sample(1'b1, 10 * 16, 1'b1));
        send_item(mk_sample(1'b0, 4095, 1'b1));
        send_item(mk_sample(1'b1, 5 * 16, 1'b0));
        send_item(mk_sample(1'b1, 15 * 16, 1'b0));
        send_item(mk_sample(1'b1, -3 * 16, 1'b0));
        send_item(mk_sample(1'b1, 20 * 16 + 15, 1'b1));

        // change the floor in the middle of a scan
        send_item(mk_sample(1'b1, 40 * 16, 1'b0));
        drain();
        write_reg(ttm_pkg::CFG_FLOOR, 8'd127);
        cfg_we <= 1'b0;
        send_item(mk_sample(1'b1, -16, 1'b1));
        send_item(mk_sample(1'b1, 0, 1'b1));
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0)
                apply_limits(8'd0, 8'd0, 8'd0, -8'sd128);
            else if (p == 1)
                apply_limits(8'd255, 8'd255, 8'd255, 8'sd127);
            else
                apply_random_limits();
            idle_pct = (p == 3) ? 0 : 30;
            if (p == 5)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_item(next_random_item((p == 5) ? 1 : 6));
            drain();
        end

        $display("tb_top: %0d samples, %0d results checked, %0d limit settings",
                 sb.samples_in, sb.results_seen, settings_applied);
        $display("tb_top: none %0d, non-recoverable %0d, critical %0d, assert %0d, %s %0d, %s %0d",
                 sb.act_seen[ttm_pkg::ACT_NONE], sb.act_seen[ttm_pkg::ACT_NONREC],
                 sb.act_seen[ttm_pkg::ACT_CRITICAL], sb.act_seen[ttm_pkg::ACT_ASSERT],
                 "deassert", sb.act_seen[ttm_pkg::ACT_DEASSERT],
                 "unavailable", sb.unavail_seen);
        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== temperature_threshold_monitor_top.f =====
sv/ttm_pkg.sv
sv/ttm_eval.sv
sv/temperature_threshold_monitor_top.sv
tb/tb_top.sv
